FILE: src/lcps_pkg.sv
package lcps_pkg;

  localparam int NUM_SENSORS_DEF = 13;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int PWM_BITS_DEF    = 8;

  // register map (byte address = 4 * index)
  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_SETPT  = 3'd1;
  localparam logic [2:0] REG_KP     = 3'd2;
  localparam logic [2:0] REG_KI     = 3'd3;
  localparam logic [2:0] REG_KD     = 3'd4;
  localparam logic [2:0] REG_BASE   = 3'd5;
  localparam logic [2:0] REG_LIMIT  = 3'd6;

  localparam logic [9:0]  THRESH_RST = 10'd680;
  localparam logic [11:0] SETPT_RST  = 12'd1364;
  localparam logic [15:0] KP_RST     = 16'd2560;
  localparam logic [15:0] KI_RST     = 16'd0;
  localparam logic [15:0] KD_RST     = 16'd25600;
  localparam logic [7:0]  BASE_RST   = 8'd80;
  localparam logic [7:0]  LIMIT_RST  = 8'd120;

  // Accumulator width for the Q.16 product sum.
  localparam int ACC_BITS = 52;

  // Request from the top level to the serial multiply unit
  typedef struct packed {
    logic        start;
    logic [15:0] gain;
    logic [31:0] value;
  } lcps_mul_req_t;

endpackage

FILE: src/line_centroid_pid_steering.sv
// Samples: one item per cycle, no result, accumulated as each is taken.
// Last item of a scan: a 17-step restoring divider, then three bit-serial
// multiplies on one shared shift-and-add unit, before out_tvalid; divider
// and multiplies are skipped when no sensor saw white.
// The input is not ready from the last item until its result is taken.
// Reset (synchronous, rst_n low): registers to defaults, accumulators and
// PID history to zero, output channel empty.
module line_centroid_pid_steering
  import lcps_pkg::*;
#(
  parameter int NUM_SENSORS = NUM_SENSORS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int PWM_BITS    = PWM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_BITS-1:0] in_tdata,  // sample
  input  logic                   in_tlast,  // last_of_scan
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // left_drive, right_drive, line_position[11:0], line_lost, drive_cut, zero pad
  output logic [((2*PWM_BITS+14+7)/8)*8-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [4:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  localparam int OUT_W  = ((2*PWM_BITS+14+7)/8)*8;
  localparam int CNT_W  = 5;
  localparam int SUM_W  = 9;
  localparam int PMAX   = (1 << PWM_BITS) - 1;

  typedef enum logic [2:0] {S_ACC, S_DIV, S_PID, S_MUL, S_DRV, S_OUT} state_t;

  // configuration registers
  logic [9:0]  thresh_r;
  logic [11:0] setpt_r;
  logic [15:0] kp_r, ki_r, kd_r;
  logic [7:0]  base_r, limit_r;
  logic        wr;
  logic [2:0]  widx;

  assign cfg_pready = 1'b1;
  assign wr   = cfg_psel & cfg_penable & cfg_pwrite;
  assign widx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RST;
      setpt_r  <= SETPT_RST;
      kp_r     <= KP_RST;
      ki_r     <= KI_RST;
      kd_r     <= KD_RST;
      base_r   <= BASE_RST;
      limit_r  <= LIMIT_RST;
    end else if (wr) begin
      unique case (widx)
        REG_THRESH: thresh_r <= cfg_pwdata[9:0];
        REG_SETPT:  setpt_r  <= cfg_pwdata[11:0];
        REG_KP:     kp_r     <= cfg_pwdata[15:0];
        REG_KI:     ki_r     <= cfg_pwdata[15:0];
        REG_KD:     kd_r     <= cfg_pwdata[15:0];
        REG_BASE:   base_r   <= cfg_pwdata[7:0];
        REG_LIMIT:  limit_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_THRESH: cfg_prdata = {22'd0, thresh_r};
      REG_SETPT:  cfg_prdata = {20'd0, setpt_r};
      REG_KP:     cfg_prdata = {16'd0, kp_r};
      REG_KI:     cfg_prdata = {16'd0, ki_r};
      REG_KD:     cfg_prdata = {16'd0, kd_r};
      REG_BASE:   cfg_prdata = {24'd0, base_r};
      REG_LIMIT:  cfg_prdata = {24'd0, limit_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // datapath state
  state_t                     state_r;
  logic [CNT_W-1:0]           cnt_r, tot_r;
  logic [SUM_W-1:0]           sum_r;
  logic signed [15:0]         perr_r;
  logic signed [31:0]         integ_r;
  logic [SUM_W+8-1:0]         quo_r;   // dividend shifts into quotient
  logic [CNT_W:0]             rem_r;
  logic [4:0]                 step_r;
  logic [1:0]                 term_r;
  logic signed [15:0]         err_r, dlt_r;
  logic [11:0]                pos_r;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;

  logic                       white;
  logic [CNT_W:0]             rem_sh;
  logic                       fits;
  logic signed [32:0]         acc33;
  logic signed [31:0]         integ_sat;
  logic signed [ACC_BITS-1:0] macc, umag, u;
  logic signed [ACC_BITS-1:0] plus, minus;
  logic                       cut;
  logic [PWM_BITS-1:0]        lft, rgt, lim;
  lcps_mul_req_t              mreq;
  logic                       mclr, mbusy;

  assign white  = ({{(16-SAMPLE_BITS){1'b0}}, in_tdata} <= 16'(thresh_r));
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W+7]};
  assign fits   = rem_sh >= {1'b0, tot_r};

  // saturating integral update
  assign acc33     = 33'(integ_r) + 33'(err_r);
  assign integ_sat = (acc33 > 33'sd2147483647)  ? 32'sh7FFFFFFF :
                     (acc33 < -33'sd2147483648) ? 32'sh80000000 : acc33[31:0];

  // truncate toward zero, then form the drives
  assign umag  = macc[ACC_BITS-1] ? -macc : macc;
  assign u     = macc[ACC_BITS-1] ? -(umag >>> 16) : (umag >>> 16);
  assign plus  = ACC_BITS'(base_r) + u;
  assign minus = ACC_BITS'(base_r) - u;
  assign cut   = plus < 0 || minus < 0 || plus > PMAX || minus > PMAX;
  assign lim   = PWM_BITS'(limit_r);
  assign lft   = (plus[PWM_BITS-1:0] > lim) ? lim : plus[PWM_BITS-1:0];
  assign rgt   = (minus[PWM_BITS-1:0] > lim) ? lim : minus[PWM_BITS-1:0];

  lcps_serial_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .clear(mclr),
    .busy (mbusy),
    .acc  (macc)
  );

  // multiplies start only after the history update cycle
  always_comb begin
    mreq.start = 1'b0;
    mreq.gain  = kp_r;
    mreq.value = 32'(err_r);
    mclr       = (state_r == S_PID);
    if (state_r == S_MUL && !mbusy && step_r != 5'd0) begin
      mreq.start = (term_r != 2'd3);
      unique case (term_r)
        2'd0:    begin mreq.gain = kp_r; mreq.value = 32'(err_r); end
        2'd1:    begin mreq.gain = ki_r; mreq.value = integ_r; end
        default: begin mreq.gain = kd_r; mreq.value = 32'(dlt_r); end
      endcase
    end
  end

  assign in_tready  = (state_r == S_ACC);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      tot_r       <= '0;
      sum_r       <= '0;
      perr_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_ACC: begin
          if (in_tvalid) begin
            if (cnt_r < CNT_W'(NUM_SENSORS)) begin
              if (white) begin
                sum_r <= sum_r + SUM_W'(cnt_r);
                tot_r <= tot_r + 1'b1;
              end
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_tlast) state_r <= S_DIV;
            quo_r  <= '0;
            rem_r  <= '0;
            step_r <= '0;
          end
        end
        S_DIV: begin
          if (step_r == 5'd0) begin
            quo_r  <= {sum_r, 8'd0};
            step_r <= 5'd1;
            if (tot_r == '0) begin
              out_data_r  <= OUT_W'({1'b0, 1'b1, 12'd0, {(2*PWM_BITS){1'b0}}});
              state_r     <= S_OUT;
            end
          end else begin
            // restoring division, one quotient bit per cycle
            rem_r  <= fits ? rem_sh - {1'b0, tot_r} : rem_sh;
            quo_r  <= {quo_r[SUM_W+6:0], fits};
            step_r <= step_r + 5'd1;
            if (step_r == 5'(SUM_W+8)) state_r <= S_PID;
          end
        end
        S_PID: begin
          pos_r   <= (quo_r > 17'd4095) ? 12'hFFF : quo_r[11:0];
          err_r   <= 16'(signed'({1'b0, setpt_r})) -
                     16'(signed'({1'b0, ((quo_r > 17'd4095) ? 12'hFFF : quo_r[11:0])}));
          term_r  <= 2'd0;
          state_r <= S_MUL;
          step_r  <= '0;
        end
        S_MUL: begin
          if (step_r == 5'd0) begin
            // first cycle: update history, then start multiplies
            dlt_r   <= err_r - perr_r;
            perr_r  <= err_r;
            integ_r <= integ_sat;
            step_r  <= 5'd1;
          end else if (!mbusy && !mreq.start && term_r == 2'd3) begin
            state_r <= S_DRV;
          end else if (mreq.start) begin
            term_r <= term_r + 2'd1;
          end
        end
        S_DRV: begin
          out_data_r <= OUT_W'({cut, 1'b0, pos_r,
                                cut ? {PWM_BITS{1'b0}} : rgt,
                                cut ? {PWM_BITS{1'b0}} : lft});
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            cnt_r <= '0;
            tot_r <= '0;
            sum_r <= '0;
          end else if (out_tready) begin
            state_r <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_valid_r) else $error("input open with result pending");
  a_lost_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2*PWM_BITS+12] |-> out_data_r[2*PWM_BITS+11:0] == '0)
    else $error("lost result carries data");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_SENSORS)) else $error("sensor count overrun");

endmodule

FILE: src/lcps_serial_mac.sv
// Bit-serial multiply-accumulate: unsigned 16-bit gain by signed 32-bit value,
// one gain bit per cycle, adding into a signed accumulator.
module lcps_serial_mac
  import lcps_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  lcps_mul_req_t              req,
  input  logic                       clear,
  output logic                       busy,
  output logic signed [ACC_BITS-1:0] acc
);

  logic [15:0]                gain_r, gain_nxt;
  logic signed [ACC_BITS-1:0] mcand_r, mcand_nxt;
  logic signed [ACC_BITS-1:0] acc_r, acc_nxt;
  logic [4:0]                 cnt_r, cnt_nxt;

  always_comb begin
    gain_nxt  = gain_r;
    mcand_nxt = mcand_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    if (clear) begin
      acc_nxt = '0;
    end
    if (req.start) begin
      gain_nxt  = req.gain;
      mcand_nxt = ACC_BITS'(signed'(req.value));
      cnt_nxt   = 5'd16;
    end else if (cnt_r != 5'd0) begin
      // one gain bit per cycle, shift-and-add
      if (gain_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      gain_nxt  = gain_r >> 1;
      mcand_nxt = mcand_r <<< 1;
      cnt_nxt   = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      acc_r <= acc_nxt;
    end
    gain_r  <= gain_nxt;
    mcand_r <= mcand_nxt;
  end

  assign busy = (cnt_r != 5'd0);
  assign acc  = acc_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'd16) else $error("mac count out of range");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> cnt_r == 5'd16) else $error("mac did not load");

endmodule
